// ----- sv/jtid_pkg.sv -----
// Package for the top-level JSON id scanner.
// Holds the transaction payload types, character codes and widths.
// No dependencies.
package jtid_pkg;

    localparam int DEPTH_BITS = 16;
    localparam int VALUE_BITS = 31;

    localparam logic [7:0] CHAR_I         = 8'h69;
    localparam logic [7:0] CHAR_D         = 8'h64;
    localparam logic [7:0] CHAR_COLON     = 8'h3A;
    localparam logic [7:0] CHAR_QUOTE     = 8'h22;
    localparam logic [7:0] CHAR_BACKSLASH = 8'h5C;
    localparam logic [7:0] CHAR_LBRACE    = 8'h7B;
    localparam logic [7:0] CHAR_LBRACKET  = 8'h5B;
    localparam logic [7:0] CHAR_RBRACE    = 8'h7D;
    localparam logic [7:0] CHAR_RBRACKET  = 8'h5D;
    localparam logic [7:0] CHAR_SPACE     = 8'h20;
    localparam logic [7:0] CHAR_TAB       = 8'h09;
    localparam logic [7:0] CHAR_CR        = 8'h0D;
    localparam logic [7:0] CHAR_ZERO      = 8'h30;
    localparam logic [7:0] CHAR_NINE      = 8'h39;

    localparam logic [VALUE_BITS-1:0] VALUE_MAX = {VALUE_BITS{1'b1}};

    typedef struct packed {
        logic [7:0] data_byte;
        logic       last_byte;
    } jtid_in_t;

    typedef struct packed {
        logic                  found;
        logic [VALUE_BITS-1:0] command_value;
    } jtid_out_t;

    typedef struct packed {
        logic      valid;
        jtid_out_t data;
    } jtid_result_t;

endpackage

// ----- sv/json_top_level_id_scanner.sv -----
// Top-level JSON id scanner: one message byte per transaction in, one result per message out.
// The result is registered: it appears on m_valid in the cycle after the last-byte transaction.
// Throughput: one byte per cycle; only a last byte stalls, while an older result is still held.
// Reset: aresetn is synchronous and active low; it clears all scanner state and the result valid flag.
// Depends on jtid_pkg and jtid_core.
module json_top_level_id_scanner (
    input  logic                aclk,
    input  logic                aresetn,
    input  logic                s_valid,
    output logic                s_ready,
    input  jtid_pkg::jtid_in_t  s_payload,
    output logic                m_valid,
    input  logic                m_ready,
    output jtid_pkg::jtid_out_t m_payload
);

    // A transaction is taken whenever valid and ready meet on the input side.
    logic                   s_fire;
    jtid_pkg::jtid_result_t core_result;

    logic                   m_valid_reg;
    jtid_pkg::jtid_out_t    m_payload_reg;

    // Bytes that are not the last one never produce a result, so they are taken
    // even while a result waits in the output register. Only a last byte has to
    // wait until the output register is free or being drained in this cycle.
    assign s_ready = !m_valid_reg || m_ready || !s_payload.last_byte;
    assign s_fire  = s_valid && s_ready;

    jtid_core u_core (
        .aclk    (aclk),
        .aresetn (aresetn),
        .accept  (s_fire),
        .in_data (s_payload),
        .result  (core_result)
    );

    // The output register holds one result transaction until it is taken.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (core_result.valid) begin
            m_valid_reg <= 1'b1;
        end else if (m_ready) begin
            m_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (core_result.valid) begin
            m_payload_reg <= core_result.data;
        end
    end

    assign m_valid   = m_valid_reg;
    assign m_payload = m_payload_reg;

    // A pending result is never overwritten by a new message end.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (s_fire && s_payload.last_byte) |-> (!m_valid_reg || m_ready))
        else $error("result overwritten before it was taken");

    // A new result only follows a last-byte transaction.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !$past(m_valid_reg)) |-> $past(s_fire && s_payload.last_byte))
        else $error("result without a last-byte transaction");

    // A miss always carries a zero value.
    assert property (@(posedge aclk) disable iff (!aresetn)
        (m_valid_reg && !m_payload_reg.found) |-> (m_payload_reg.command_value == '0))
        else $error("nonzero value on a miss");

endmodule

// ----- sv/jtid_core.sv -----
// Scanner state and per-byte next-state logic for the JSON id scanner.
// Depends on jtid_pkg for payload types and character codes.
module jtid_core (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  accept,
    input  jtid_pkg::jtid_in_t    in_data,
    output jtid_pkg::jtid_result_t result
);

    typedef enum logic [2:0] {
        PH_SCAN   = 3'd0,
        PH_WS1    = 3'd1,
        PH_WS2    = 3'd2,
        PH_DIGITS = 3'd3,
        PH_FOUND  = 3'd4,
        PH_MISS   = 3'd5
    } phase_t;

    phase_t                              phase_reg, phase_next;
    logic                                in_str_reg, in_str_next;
    logic                                esc_reg, esc_next;
    logic [jtid_pkg::DEPTH_BITS-1:0]     depth_reg, depth_next;
    logic [1:0]                          len_reg, len_next;
    logic [1:0]                          prefix_reg, prefix_next;
    logic [jtid_pkg::VALUE_BITS-1:0]     acc_reg, acc_next;

    logic [7:0]                          c;
    logic                                is_space, is_digit;
    logic [3:0]                          digit;
    logic [jtid_pkg::VALUE_BITS+4:0]     acc_times_ten;
    logic [jtid_pkg::VALUE_BITS+4:0]     acc_sum;
    logic                                do_scan;
    logic                                count_byte;
    logic                                found_w;

    assign c        = in_data.data_byte;
    assign is_space = (c == jtid_pkg::CHAR_SPACE) ||
                      ((c >= jtid_pkg::CHAR_TAB) && (c <= jtid_pkg::CHAR_CR));
    assign is_digit = (c >= jtid_pkg::CHAR_ZERO) && (c <= jtid_pkg::CHAR_NINE);
    assign digit    = 4'(c - jtid_pkg::CHAR_ZERO);

    // Multiply by ten as (8x + 2x), then add the new digit.
    assign acc_times_ten = {2'b00, acc_reg, 3'b000} + {4'b0000, acc_reg, 1'b0};
    assign acc_sum       = acc_times_ten + {{(jtid_pkg::VALUE_BITS+1){1'b0}}, digit};

    always_comb begin
        phase_next  = phase_reg;
        in_str_next = in_str_reg;
        esc_next    = esc_reg;
        depth_next  = depth_reg;
        len_next    = len_reg;
        prefix_next = prefix_reg;
        acc_next    = acc_reg;
        do_scan     = 1'b0;
        count_byte  = 1'b0;

        case (phase_reg)
            PH_WS1: begin
                if (is_space) begin
                    phase_next = PH_WS1;
                end else if (c == jtid_pkg::CHAR_COLON) begin
                    phase_next = PH_WS2;
                end else begin
                    phase_next = PH_SCAN;
                    do_scan    = 1'b1;
                end
            end
            PH_WS2: begin
                if (is_space) begin
                    phase_next = PH_WS2;
                end else if (is_digit) begin
                    phase_next = PH_DIGITS;
                    acc_next   = {{(jtid_pkg::VALUE_BITS-4){1'b0}}, digit};
                end else begin
                    phase_next = PH_SCAN;
                    do_scan    = 1'b1;
                end
            end
            PH_DIGITS: begin
                if (is_digit) begin
                    if (acc_sum > {5'b00000, jtid_pkg::VALUE_MAX}) begin
                        phase_next = PH_MISS;
                        acc_next   = '0;
                    end else begin
                        acc_next = acc_sum[jtid_pkg::VALUE_BITS-1:0];
                    end
                end else begin
                    phase_next = PH_FOUND;
                end
            end
            PH_FOUND, PH_MISS: begin
                phase_next = phase_reg;
            end
            default: begin
                phase_next = PH_SCAN;
                do_scan    = 1'b1;
            end
        endcase

        if (do_scan) begin
            if (in_str_reg) begin
                if (esc_reg) begin
                    esc_next   = 1'b0;
                    count_byte = 1'b1;
                end else if (c == jtid_pkg::CHAR_BACKSLASH) begin
                    esc_next   = 1'b1;
                    count_byte = 1'b1;
                end else if (c == jtid_pkg::CHAR_QUOTE) begin
                    in_str_next = 1'b0;
                    if ((depth_reg == jtid_pkg::DEPTH_BITS'(1)) && (len_reg == 2'd2) &&
                        (prefix_reg == 2'b11)) begin
                        phase_next = PH_WS1;
                    end
                end else begin
                    count_byte = 1'b1;
                end
            end else if (c == jtid_pkg::CHAR_QUOTE) begin
                in_str_next = 1'b1;
                len_next    = '0;
                prefix_next = '0;
            end else if ((c == jtid_pkg::CHAR_LBRACE) || (c == jtid_pkg::CHAR_LBRACKET)) begin
                if (depth_reg != {jtid_pkg::DEPTH_BITS{1'b1}}) begin
                    depth_next = depth_reg + 1'b1;
                end
            end else if (((c == jtid_pkg::CHAR_RBRACE) || (c == jtid_pkg::CHAR_RBRACKET)) &&
                         (depth_reg != '0)) begin
                depth_next = depth_reg - 1'b1;
            end
        end

        if (count_byte) begin
            if ((len_reg == 2'd0) && (c == jtid_pkg::CHAR_I)) begin
                prefix_next[0] = 1'b1;
            end
            if ((len_reg == 2'd1) && (c == jtid_pkg::CHAR_D)) begin
                prefix_next[1] = 1'b1;
            end
            if (len_reg != 2'd3) begin
                len_next = len_reg + 1'b1;
            end
        end
    end

    assign found_w = (phase_next == PH_DIGITS) || (phase_next == PH_FOUND);

    always_comb begin
        result.valid              = accept && in_data.last_byte;
        result.data.found         = found_w;
        result.data.command_value = found_w ? acc_next : '0;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg  <= PH_SCAN;
            in_str_reg <= 1'b0;
            esc_reg    <= 1'b0;
            depth_reg  <= '0;
            len_reg    <= '0;
            prefix_reg <= '0;
            acc_reg    <= '0;
        end else if (accept) begin
            if (in_data.last_byte) begin
                phase_reg  <= PH_SCAN;
                in_str_reg <= 1'b0;
                esc_reg    <= 1'b0;
                depth_reg  <= '0;
                len_reg    <= '0;
                prefix_reg <= '0;
                acc_reg    <= '0;
            end else begin
                phase_reg  <= phase_next;
                in_str_reg <= in_str_next;
                esc_reg    <= esc_next;
                depth_reg  <= depth_next;
                len_reg    <= len_next;
                prefix_reg <= prefix_next;
                acc_reg    <= acc_next;
            end
        end
    end

endmodule
